// File: rtl/core/gchk_pkg.sv
// Shared types, constants and helper functions for the grid cell hash key unit.
// Used by gchk_div, gchk_dp, gchk_ctrl and grid_cell_hash_keys_unit.
package gchk_pkg;

    localparam int EDGE_W   = 48;           // signed Q32.16 edge
    localparam int CS_W     = EDGE_W - 1;   // cell size register width
    localparam int LIMIT_W  = 7;            // max cells register width
    localparam int SPAN_W   = EDGE_W + 1;   // cell index difference
    localparam int ZZ_W     = EDGE_W + 1;   // zigzag-mapped index
    localparam int HASH_W   = 64;
    localparam int KEY_W    = 63;
    localparam int MAX_RUN  = 64;
    localparam int N_EDGES  = 4;
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = HASH_W / MUL_CHUNK;

    localparam logic [HASH_W-1:0] MIX_MUL  = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] MIX_ADD  = 64'h517cc1b727220a95;
    // products for a zigzag step of +2, -1 and -2
    localparam logic [HASH_W-1:0] MUL_P2   = {MIX_MUL[HASH_W-2:0], 1'b0};
    localparam logic [HASH_W-1:0] MUL_M1   = ~MIX_MUL + 64'd1;
    localparam logic [HASH_W-1:0] MUL_M2   = ~MUL_P2 + 64'd1;
    localparam logic [HASH_W-1:0] INC_P2   = 64'd2;
    localparam logic [HASH_W-1:0] INC_M1   = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] INC_M2   = {{(HASH_W-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVERTED = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_store;
        logic    span;
        logic    mul_clear;
        logic    mul_step;
        logic    row_init;
        logic    x_step;
        logic    row_next;
        logic    emit;
        logic    err_emit;
        t_status err_code;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic div_last;
        logic inverted;
        logic too_many;
        logic mul_last;
        logic x_end;
        logic y_end;
        logic out_free;
    } t_dp_stat;

    // 2v for v >= 0, 2(-v-1)+1 otherwise
    function automatic logic [ZZ_W-1:0] zigzag(input logic [EDGE_W-1:0] v);
        zigzag = {v ^ {EDGE_W{v[EDGE_W-1]}}, v[EDGE_W-1]};
    endfunction

endpackage

// File: rtl/core/gchk_div.sv
// Iterative floor divider: signed edge by unsigned cell size, one bit per cycle.
// Depends on gchk_pkg for widths.
module gchk_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gchk_pkg::EDGE_W-1:0]   i_dividend,
    input  logic [gchk_pkg::CS_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [gchk_pkg::EDGE_W-1:0]   o_quot
);
    import gchk_pkg::*;

    localparam int CNT_W = $clog2(EDGE_W);

    logic              r_busy, r_done, r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [EDGE_W-1:0] r_rem, r_qm;
    logic [EDGE_W-1:0] rem_sh, dvs, rem_nx;
    logic              ge;

    assign rem_sh = {r_rem[EDGE_W-2:0], r_qm[EDGE_W-1]};
    assign dvs    = {1'b0, i_divisor};
    assign ge     = (rem_sh >= dvs);
    assign rem_nx = ge ? (rem_sh - dvs) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(EDGE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[EDGE_W-1];
            r_qm  <= i_dividend[EDGE_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_qm  <= {r_qm[EDGE_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // round toward minus infinity for negative dividends
    assign o_quot = !r_neg ? r_qm : ((|r_rem) ? ~r_qm : (~r_qm + 1'b1));
    assign o_done = r_done;

endmodule

// File: rtl/core/gchk_dp.sv
// Datapath: edge and cell registers, divider, span check, seed multiply,
// incremental hash mixing and the output register. Depends on gchk_pkg, gchk_div.
module gchk_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gchk_pkg::t_dp_cmd               i_cmd,
    output gchk_pkg::t_dp_stat              o_stat,
    input  logic [4*gchk_pkg::EDGE_W-1:0]   i_edges,
    input  logic [gchk_pkg::CS_W-1:0]       i_cell_len,
    input  logic [gchk_pkg::LIMIT_W-1:0]    i_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gchk_pkg::KEY_W-1:0]      o_out_key,
    output logic                            o_out_last,
    output logic [1:0]                      o_out_status
);
    import gchk_pkg::*;

    localparam int IDX_W  = $clog2(N_EDGES);
    localparam int MCNT_W = $clog2(MUL_STEPS);
    localparam int SH_W   = $clog2(HASH_W);
    localparam int RUN_W  = $clog2(MAX_RUN);

    // edge order: min_x, min_y, max_x, max_y
    logic [EDGE_W-1:0] r_edge [N_EDGES];
    logic [EDGE_W-1:0] r_cell [N_EDGES];
    logic [IDX_W-1:0]  r_div_idx;
    logic [SPAN_W-1:0] r_dx, r_dy;
    logic [MCNT_W-1:0] r_mcnt;
    logic [HASH_W-1:0] r_acc, r_prod, r_ybase;
    logic [EDGE_W-1:0] r_x, r_y;
    logic              r_out_valid, r_out_last;
    logic [KEY_W-1:0]  r_out_key;
    t_status           r_out_status;

    logic [CS_W-1:0]   divisor;
    logic              div_done;
    logic [EDGE_W-1:0] div_quot;

    assign divisor = (i_cell_len == '0) ? CS_W'(1) : i_cell_len;

    gchk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_edge[r_div_idx]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // span limit check
    logic [LIMIT_W-1:0]   w_cnt, h_cnt, limit;
    logic [2*LIMIT_W-1:0] area;
    logic                 span_big;

    assign limit    = (i_limit > LIMIT_W'(MAX_RUN)) ? LIMIT_W'(MAX_RUN) : i_limit;
    assign w_cnt    = LIMIT_W'(r_dx[RUN_W-1:0]) + 1'b1;
    assign h_cnt    = LIMIT_W'(r_dy[RUN_W-1:0]) + 1'b1;
    assign area     = w_cnt * h_cnt;
    assign span_big = (|r_dx[SPAN_W-1:RUN_W]) || (|r_dy[SPAN_W-1:RUN_W]);

    // seed multiply: zigzag(cx0) * MIX_MUL, one 16-bit chunk per cycle
    logic [HASH_W-1:0]           ux0;
    logic [MUL_CHUNK-1:0]        chunk;
    logic [MUL_CHUNK+HASH_W-1:0] part;
    logic [SH_W-1:0]             shamt;

    assign ux0   = HASH_W'(zigzag(r_cell[0]));
    assign shamt = SH_W'(r_mcnt) * SH_W'(MUL_CHUNK);
    assign chunk = MUL_CHUNK'(ux0 >> shamt);
    assign part  = chunk * MIX_MUL;

    // hash of the current cell
    logic [HASH_W-1:0] ux, mix, key;
    assign ux  = HASH_W'(zigzag(r_x));
    assign mix = r_ybase + (ux << 6) + (ux >> 2);
    assign key = r_prod ^ mix;

    logic [HASH_W-1:0] prod_inc, yb_inc, yb_init;
    always_comb begin
        if (!r_x[EDGE_W-1]) begin
            prod_inc = MUL_P2;
        end else if (&r_x) begin
            prod_inc = MUL_M1;
        end else begin
            prod_inc = MUL_M2;
        end
        if (!r_y[EDGE_W-1]) begin
            yb_inc = INC_P2;
        end else if (&r_y) begin
            yb_inc = INC_M1;
        end else begin
            yb_inc = INC_M2;
        end
    end
    assign yb_init = HASH_W'(zigzag(r_cell[1])) + MIX_ADD;

    logic x_end, y_end;
    assign x_end = (r_x == r_cell[2]);
    assign y_end = (r_y == r_cell[3]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < N_EDGES; i++) begin
                r_edge[i] <= i_edges[i*EDGE_W +: EDGE_W];
            end
            r_div_idx <= '0;
        end
        if (i_cmd.div_store) begin
            r_cell[r_div_idx] <= div_quot;
            r_div_idx         <= r_div_idx + 1'b1;
        end
        if (i_cmd.span) begin
            r_dx <= {r_cell[2][EDGE_W-1], r_cell[2]} - {r_cell[0][EDGE_W-1], r_cell[0]};
            r_dy <= {r_cell[3][EDGE_W-1], r_cell[3]} - {r_cell[1][EDGE_W-1], r_cell[1]};
        end
        if (i_cmd.mul_clear) begin
            r_acc   <= '0;
            r_mcnt  <= '0;
            r_y     <= r_cell[1];
            r_ybase <= yb_init;
        end
        if (i_cmd.mul_step) begin
            r_acc  <= r_acc + (part[HASH_W-1:0] << shamt);
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.row_init || i_cmd.row_next) begin
            r_x    <= r_cell[0];
            r_prod <= r_acc;
        end
        if (i_cmd.row_next) begin
            r_y     <= r_y + 1'b1;
            r_ybase <= r_ybase + yb_inc;
        end
        if (i_cmd.x_step) begin
            r_x    <= r_x + 1'b1;
            r_prod <= r_prod + prod_inc;
        end
        if (i_cmd.emit) begin
            r_out_key    <= key[KEY_W-1:0];
            r_out_last   <= x_end && y_end;
            r_out_status <= ST_OK;
        end else if (i_cmd.err_emit) begin
            r_out_key    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= i_cmd.err_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.err_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.div_last = (r_div_idx == IDX_W'(N_EDGES - 1));
    assign o_stat.inverted = r_dx[SPAN_W-1] || r_dy[SPAN_W-1];
    assign o_stat.too_many = span_big || (area > (2*LIMIT_W)'(limit));
    assign o_stat.mul_last = (r_mcnt == MCNT_W'(MUL_STEPS - 1));
    assign o_stat.x_end    = x_end;
    assign o_stat.y_end    = y_end;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

// File: rtl/core/gchk_ctrl.sv
// Controller state machine: sequences divisions, checks, seed multiply and
// key emission. Depends on gchk_pkg for command and status structs.
module gchk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gchk_pkg::t_dp_stat  i_stat,
    output gchk_pkg::t_dp_cmd   o_cmd
);
    import gchk_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DLOAD = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_SPAN  = 9'b000001000,
        S_LIMIT = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ROW   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_ERR   = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_err        = r_err;
        o_cmd        = '0;
        o_cmd.err_code = r_err;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state = i_stat.div_last ? S_SPAN : S_DLOAD;
                end
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_LIMIT;
            end
            S_LIMIT: begin
                // inverted range wins over the coverage limit
                if (i_stat.inverted) begin
                    n_err   = ST_INVERTED;
                    n_state = S_ERR;
                end else if (i_stat.too_many) begin
                    n_err   = ST_TOO_MANY;
                    n_state = S_ERR;
                end else begin
                    o_cmd.mul_clear = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_init = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_stat.x_end) begin
                        o_cmd.x_step = 1'b1;
                    end else if (!i_stat.y_end) begin
                        o_cmd.row_next = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.err_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/grid_cell_hash_keys_unit.sv
// Grid cell hash keys: one rectangle in, one hash key per covered cell out.
// The four floor divisions run on the shared bit-serial divider, followed by
// the span and limit checks and the seed multiply before the first key.
// Throughput: one key per cycle while the output is taken; one rectangle at a
// time. Synchronous active-low reset clears control state and restores the
// cell size 256.0 and the limit 64.
module grid_cell_hash_keys_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // min_x[47:0], min_y, max_x, max_y
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // cell_key[62:0], zero pad
    output logic         m_axis_tlast,
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import gchk_pkg::*;

    localparam logic REG_CELL_LEN  = 1'b0;
    localparam logic REG_MAX_CELLS = 1'b1;

    logic [CS_W-1:0]    r_cell_len;
    logic [LIMIT_W-1:0] r_max_cells;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_len  <= CS_W'(64'd16777216);
            r_max_cells <= LIMIT_W'(MAX_RUN);
        end else if (wr_en) begin
            if (paddr[3] == REG_CELL_LEN) begin
                r_cell_len <= pwdata[CS_W-1:0];
            end else begin
                r_max_cells <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[3])
            REG_CELL_LEN:  prdata = 64'(r_cell_len);
            REG_MAX_CELLS: prdata = 64'(r_max_cells);
            default:       prdata = '0;
        endcase
    end

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [KEY_W-1:0] out_key;

    gchk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gchk_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_edges      (s_axis_tdata),
        .i_cell_len   (r_cell_len),
        .i_limit      (r_max_cells),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_key    (out_key),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_key};

endmodule
